FILE: src/sut_pkg.sv
// Shared constants, types and command struct for the sorted unique table.
package sut_pkg;

    localparam int CAPACITY = 256;
    localparam int DATA_W   = 32;
    localparam int IDX_W    = 8;
    localparam int CNT_W    = 9;
    localparam int GRP_W    = 4;
    localparam int GRP_SIZE = 16;
    localparam int GRP_CNT  = CAPACITY / GRP_SIZE;
    localparam int OUT_W    = 24;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_RED,
        ST_FIN
    } sut_state_t;

    typedef struct packed {
        logic                     cmp;
        logic                     ins;
        logic signed [DATA_W-1:0] key;
        logic [CNT_W-1:0]         count;
    } sut_cmd_t;

endpackage

FILE: src/sut_cell.sv
// One table cell: holds an entry, compares it with the key, shifts on insert.
module sut_cell (
    input  logic                              clk,
    input  logic [sut_pkg::IDX_W-1:0]         idx,
    input  sut_pkg::sut_cmd_t                 cmd,
    input  logic signed [sut_pkg::DATA_W-1:0] left_value,
    input  logic                              left_gt,
    output logic signed [sut_pkg::DATA_W-1:0] value,
    output logic                              gt,
    output logic                              eq
);
    import sut_pkg::*;

    logic signed [DATA_W-1:0] value_reg;
    logic                     gt_reg;
    logic                     eq_reg;
    logic                     occupied;
    logic                     at_end;

    assign occupied = {1'b0, idx} < cmd.count;
    assign at_end   = {1'b0, idx} == cmd.count;

    always_ff @(posedge clk)
    begin
        if (cmd.cmp)
        begin
            eq_reg <= occupied && (value_reg == cmd.key);
            gt_reg <= occupied && (value_reg > cmd.key);
        end
        if (cmd.ins)
        begin
            if (left_gt)
            begin
                value_reg <= left_value;
            end
            else if (gt_reg || at_end)
            begin
                value_reg <= cmd.key;
            end
        end
    end

    assign value = value_reg;
    assign gt    = gt_reg;
    assign eq    = eq_reg;

endmodule

FILE: src/sut_grp.sv
// Group reduction: registers hit and local index over a group of cell matches.
module sut_grp (
    input  logic                        clk,
    input  logic                        en,
    input  logic [sut_pkg::GRP_SIZE-1:0] eq,
    output logic                        hit,
    output logic [sut_pkg::GRP_W-1:0]   pos
);
    import sut_pkg::*;

    logic             hit_reg;
    logic [GRP_W-1:0] pos_reg;
    logic [GRP_W-1:0] pos_next;

    always_comb
    begin
        pos_next = '0;
        for (int j = 0; j < GRP_SIZE; j++)
        begin
            if (eq[j])
            begin
                pos_next = pos_next | GRP_W'(j);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg <= |eq;
            pos_reg <= pos_next;
        end
    end

    assign hit = hit_reg;
    assign pos = pos_reg;

endmodule

FILE: src/sorted_unique_table_top.sv
// Top level of the sorted unique table: control, cell row, reduction and output.
//
// Holds up to 256 distinct signed 32-bit values in ascending order in a row of
// cells. A lookup returns found and the entry's position; an insert is refused
// for a duplicate or a full table, otherwise larger entries shift up one cell
// and the count grows. Every item gets one result. After acceptance, the cells
// compare against the key, the 16-cell groups are reduced, and then the groups
// are merged, the row shifts and the result is loaded into the output register;
// that last step holds while the output register is full and not being taken.
// The next item is accepted in the cycle after the result is loaded, so a new
// item is not taken until the last one has its result. Reset empties the table
// at once.
module sorted_unique_table_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [sut_pkg::DATA_W-1:0]   s_tdata,  // value[31:0]
    input  logic                         s_tuser,  // op
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [sut_pkg::OUT_W-1:0]    m_tdata   // found, position[7:0], inserted,
                                                   // entry_count[8:0], zero pad
);
    import sut_pkg::*;

    sut_state_t               state_reg;
    sut_state_t               state_next;
    logic signed [DATA_W-1:0] key_reg;
    logic                     op_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [OUT_W-1:0]         out_data_reg;
    logic [OUT_W-1:0]         out_data_next;

    sut_cmd_t                 cmd;
    logic signed [DATA_W-1:0] cell_value [CAPACITY];
    logic [CAPACITY-1:0]      cell_gt;
    logic [CAPACITY-1:0]      cell_eq;
    logic [GRP_CNT-1:0]       grp_hit;
    logic [GRP_W-1:0]         grp_pos [GRP_CNT];

    logic                     found_c;
    logic [IDX_W-1:0]         pos_c;
    logic                     out_free;
    logic                     ins_ok;
    logic                     do_ins;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic signed [DATA_W-1:0] lv;
            logic                     lg;
            if (gi == 0)
            begin : g_first
                assign lv = '0;
                assign lg = 1'b0;
            end
            else
            begin : g_rest
                assign lv = cell_value[gi-1];
                assign lg = cell_gt[gi-1];
            end
            sut_cell u_cell (
                .clk        (clk),
                .idx        (IDX_W'(gi)),
                .cmd        (cmd),
                .left_value (lv),
                .left_gt    (lg),
                .value      (cell_value[gi]),
                .gt         (cell_gt[gi]),
                .eq         (cell_eq[gi])
            );
        end
        for (gi = 0; gi < GRP_CNT; gi++)
        begin : g_grp
            sut_grp u_grp (
                .clk (clk),
                .en  (state_reg == ST_RED),
                .eq  (cell_eq[gi*GRP_SIZE +: GRP_SIZE]),
                .hit (grp_hit[gi]),
                .pos (grp_pos[gi])
            );
        end
    endgenerate

    always_comb
    begin
        found_c = 1'b0;
        pos_c   = '0;
        for (int g = 0; g < GRP_CNT; g++)
        begin
            if (grp_hit[g])
            begin
                found_c = 1'b1;
                pos_c   = pos_c | {(IDX_W-GRP_W)'(g), grp_pos[g]};
            end
        end
    end

    assign out_free  = !out_valid_reg || m_tready;
    assign ins_ok    = (op_reg == OP_INSERT) && !found_c && (count_reg != CNT_W'(CAPACITY));
    assign do_ins    = (state_reg == ST_FIN) && out_free && ins_ok;

    assign cmd.cmp   = (state_reg == ST_CMP);
    assign cmd.ins   = do_ins;
    assign cmd.key   = key_reg;
    assign cmd.count = count_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = ST_RED;
            end
            ST_RED:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    if (do_ins)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    out_data_next[0]     = (op_reg == OP_LOOKUP) && found_c;
                    out_data_next[8:1]   = ((op_reg == OP_LOOKUP) && found_c) ? pos_c : '0;
                    out_data_next[9]     = ins_ok;
                    out_data_next[18:10] = count_next;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            key_reg <= s_tdata;
            op_reg  <= s_tuser;
        end
        out_data_reg <= out_data_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != $past(count_reg) |-> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("entry count moved by other than one");

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[0] && m_tdata[9]))
        else $error("found and inserted both set");

    a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> state_reg == ST_CMP)
        else $error("accepted item did not enter compare");

    a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
        do_ins |=> m_tvalid && m_tdata[9] && m_tdata[18:10] == count_reg)
        else $error("insert result does not match count");

endmodule
